### design/glzw_pkg.sv
package glzw_pkg;
  localparam int unsigned DefMaxCodes  = 4096;
  localparam int unsigned DefHashSlots = 8192;
  localparam int unsigned HashMult     = 40503;

  // controller -> datapath commands
  typedef struct packed {
    logic start_px;     // latch pixel, compute hash
    logic load_first;   // first pixel of image
    logic probe_rd;     // issue read at probe slot
    logic probe_adv;    // step probe slot
    logic hit_take;     // prefix <= found code
    logic miss_emit;    // queue prefix code, insert/restart
    logic write_ent;    // write entry at probe slot
    logic put_last;     // queue prefix and end code
    logic flush;        // emit partial byte
    logic pop_byte;     // one byte sent downstream
    logic clr_sweep;    // clear one valid row
  } glzw_cmd_t;

  typedef struct packed {
    logic rd_valid;
    logic rd_match;
    logic have_byte;    // >= 8 bits buffered
    logic exact_byte;   // exactly 8 bits buffered
    logic have_bits;    // any bits buffered
    logic full_dict;    // next_code at limit
    logic sweep_done;
    logic pend_codes;   // codes waiting to be packed
  } glzw_sts_t;
endpackage

### design/glzw_datapath.sv
module glzw_datapath #(
  parameter int unsigned MAX_CODES  = glzw_pkg::DefMaxCodes,
  parameter int unsigned HASH_SLOTS = glzw_pkg::DefHashSlots
) (
  input  logic                clk,
  input  logic                rst_n,
  input  glzw_pkg::glzw_cmd_t cmd,
  output glzw_pkg::glzw_sts_t sts,
  input  logic [8:0]          color_count,
  input  logic [7:0]          in_pixel,
  output logic [7:0]          cur_byte,
  output logic [3:0]          min_size,
  output logic                err_flag
);
  import glzw_pkg::*;
  localparam int SW = $clog2(HASH_SLOTS);

  // effective clear code
  logic [8:0] eff_m1;
  logic [3:0] clr_bits;
  logic [12:0] clr;
  always_comb begin
    if (color_count == 9'd0) eff_m1 = 9'd0;
    else if (color_count > 9'd256) eff_m1 = 9'd255;
    else eff_m1 = color_count - 9'd1;
    clr_bits = 4'd1;
    for (int i = 1; i < 8; i++) if (eff_m1[i]) clr_bits = 4'(i + 1);
    clr = 13'd1 << clr_bits;
  end
  assign min_size = clr_bits;

  logic [7:0]  pix_r;
  logic [11:0] prefix_r;
  logic [12:0] next_code_r;
  logic [3:0]  width_r;
  logic        err_r;
  logic [SW-1:0] slot_r;
  logic [23:0] buf_r;
  logic [4:0]  cnt_r;
  // small queue of codes to pack (at most 2 pending)
  logic [12:0] q_code_r [2];
  logic [3:0]  q_w_r [2];
  logic [1:0]  q_n_r;

  // memory: valid bits kept in a separate RAM cleared by sweep
  logic [31:0] mem [HASH_SLOTS];
  logic        vmem [HASH_SLOTS];
  logic [31:0] rd_r;
  logic        rdv_r, rd_ok_r;
  logic [SW-1:0] sweep_r;

  logic [19:0] key;
  logic [SW-1:0] hash;
  logic bad;
  assign bad = {1'b0, in_pixel} > eff_m1;
  assign key = {prefix_r, (bad ? 8'd0 : in_pixel)};
  assign hash = SW'((32'(key) * HashMult) % HASH_SLOTS);

  always_ff @(posedge clk) begin
    if (cmd.write_ent) begin
      mem[slot_r] <= {prefix_r, pix_r, next_code_r[11:0]};
      vmem[slot_r] <= 1'b1;
    end else if (cmd.clr_sweep) vmem[sweep_r] <= 1'b0;
    if (cmd.probe_rd) begin
      rd_r <= mem[slot_r];
      rdv_r <= vmem[slot_r];
    end
  end

  // code width growth
  logic [3:0] cand;
  always_comb begin
    cand = 4'd1;
    for (int i = 1; i < 13; i++) if (next_code_r[i]) cand = 4'(i + 1);
  end

  logic [23:0] buf_nxt;
  logic [4:0]  cnt_nxt;
  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (cmd.flush) begin
      buf_nxt = '0;
      cnt_nxt = '0;
    end else if (cmd.pop_byte) begin
      buf_nxt = buf_r >> 8;
      cnt_nxt = (cnt_r >= 5'd8) ? cnt_r - 5'd8 : 5'd0;
    end else if (q_n_r != 2'd0 && cnt_r < 5'd8) begin
      buf_nxt = buf_r | (24'(q_code_r[0] & ((13'd1 << q_w_r[0]) - 13'd1)) << cnt_r);
      cnt_nxt = cnt_r + 5'(q_w_r[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_code_r <= 13'd258; width_r <= 4'd9; prefix_r <= '0; err_r <= 1'b0;
      buf_r <= '0; cnt_r <= '0; q_n_r <= '0; sweep_r <= '0; rd_ok_r <= 1'b0;
    end else begin
      buf_r <= buf_nxt; cnt_r <= cnt_nxt;
      if (!(cmd.pop_byte || cmd.flush) && q_n_r != 2'd0 && cnt_r < 5'd8) begin
        q_code_r[0] <= q_code_r[1]; q_w_r[0] <= q_w_r[1]; q_n_r <= q_n_r - 2'd1;
      end
      if (cmd.clr_sweep) sweep_r <= sweep_r + SW'(1);
      rd_ok_r <= cmd.probe_rd;
      if (cmd.start_px) begin
        pix_r <= bad ? 8'd0 : in_pixel;
        slot_r <= hash;
        if (cmd.load_first) begin
          err_r <= bad;
          next_code_r <= clr + 13'd2;
          width_r <= clr_bits + 4'd1;
          q_code_r[0] <= clr; q_w_r[0] <= clr_bits + 4'd1; q_n_r <= 2'd1;
          prefix_r <= {4'd0, (bad ? 8'd0 : in_pixel)};
        end else if (bad) err_r <= 1'b1;
      end
      if (cmd.probe_adv) slot_r <= slot_r + SW'(1);
      if (cmd.hit_take) prefix_r <= rd_r[11:0];
      if (cmd.miss_emit) begin
        q_code_r[0] <= {1'b0, prefix_r}; q_w_r[0] <= width_r;
        prefix_r <= {4'd0, pix_r};
        if (next_code_r < 13'(MAX_CODES)) begin
          next_code_r <= next_code_r + 13'd1;
          q_n_r <= 2'd1;
          if (cand > width_r) width_r <= cand;
        end else begin
          q_code_r[1] <= clr; q_w_r[1] <= width_r; q_n_r <= 2'd2;
          next_code_r <= clr + 13'd2;
          width_r <= clr_bits + 4'd1;
        end
      end
      if (cmd.put_last) begin
        q_code_r[0] <= {1'b0, prefix_r}; q_w_r[0] <= width_r;
        q_code_r[1] <= clr + 13'd1; q_w_r[1] <= width_r; q_n_r <= 2'd2;
      end
    end
  end

  assign cur_byte = buf_r[7:0];
  assign err_flag = err_r;
  assign sts.rd_valid = rd_ok_r && rdv_r;
  assign sts.rd_match = rd_r[31:12] == {prefix_r, pix_r};
  assign sts.have_byte = cnt_r >= 5'd8;
  assign sts.exact_byte = cnt_r == 5'd8;
  assign sts.have_bits = cnt_r != 5'd0;
  assign sts.full_dict = next_code_r >= 13'(MAX_CODES);
  assign sts.sweep_done = &sweep_r;
  assign sts.pend_codes = q_n_r != 2'd0;
endmodule

### design/glzw_ctrl.sv
module glzw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_last,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic                out_last,
  output glzw_pkg::glzw_cmd_t cmd,
  input  glzw_pkg::glzw_sts_t sts
);
  import glzw_pkg::*;

  typedef enum logic [8:0] {
    S_SWEEP = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RD    = 9'b000000100,
    S_CHK   = 9'b000001000,
    S_PACK  = 9'b000010000,
    S_LAST  = 9'b000100000,
    S_LPACK = 9'b001000000,
    S_FLUSH = 9'b010000000,
    S_CLR   = 9'b100000000
  } st_t;

  st_t st_r, st_nxt;
  logic started_r, started_nxt, last_r, last_nxt;
  logic wipe_r, wipe_nxt;   // table restart: sweep after packing

  always_comb begin
    st_nxt = st_r; started_nxt = started_r; last_nxt = last_r; wipe_nxt = wipe_r;
    cmd = '0; in_tready = 1'b0; out_tvalid = 1'b0; out_last = 1'b0;
    unique case (st_r)
      S_SWEEP, S_CLR: begin
        cmd.clr_sweep = 1'b1;
        wipe_nxt = 1'b0;
        if (sts.sweep_done) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start_px = 1'b1;
          last_nxt = in_last;
          if (!started_r) begin
            cmd.load_first = 1'b1; started_nxt = 1'b1;
            st_nxt = S_PACK;
          end else st_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.probe_rd = 1'b1; st_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.rd_valid && sts.rd_match) begin
          cmd.hit_take = 1'b1;
          st_nxt = last_r ? S_LAST : S_IDLE;
        end else if (sts.rd_valid) begin
          cmd.probe_adv = 1'b1; st_nxt = S_RD;
        end else begin
          if (!sts.full_dict) cmd.write_ent = 1'b1;
          else wipe_nxt = 1'b1;
          cmd.miss_emit = 1'b1;
          st_nxt = S_PACK;
        end
      end
      S_PACK, S_LPACK: begin
        if (sts.have_byte) begin
          out_tvalid = 1'b1;
          out_last = (st_r == S_LPACK) && sts.exact_byte && !sts.pend_codes;
          if (out_tready) cmd.pop_byte = 1'b1;
        end else if (!sts.pend_codes) begin
          if (st_r == S_LPACK) st_nxt = S_FLUSH;
          else if (last_r) st_nxt = S_LAST;
          else if (wipe_r) st_nxt = S_CLR;
          else st_nxt = S_IDLE;
        end
      end
      S_LAST: begin
        cmd.put_last = 1'b1; last_nxt = 1'b0; st_nxt = S_LPACK;
      end
      S_FLUSH: begin
        started_nxt = 1'b0;
        if (sts.have_bits) begin
          out_tvalid = 1'b1; out_last = 1'b1;
          if (out_tready) begin
            cmd.flush = 1'b1; st_nxt = S_CLR;
          end
        end else st_nxt = S_CLR;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_SWEEP; started_r <= 1'b0; last_r <= 1'b0; wipe_r <= 1'b0;
    end else begin
      st_r <= st_nxt; started_r <= started_nxt; last_r <= last_nxt; wipe_r <= wipe_nxt;
    end
  end
endmodule

### design/gif_lzw_compressor.sv
// GIF-style LZW compressor.
// Input: in_tdata = pixel (palette index), in_tlast marks the last pixel.
// Output: out_tdata = packed code byte (LSB-first bits); out_tuser carries
// min code size and the bad-pixel flag; out_tlast marks the last word.
// cfg_we/cfg_wdata write color_count; write only while idle.
// Per pixel: an accept state, then per hash probe a read and a compare state
// in the dictionary RAM; the first pixel of an image skips the probes. A
// first-probe hit goes back to accept. A miss adds packing of each code,
// sending of each word and a closing step before the next accept.
// The last pixel adds a state to queue its code and the end code, then their
// packing and a flush word if bits remain; then the valid RAM is swept again.
// Reset: a clearing pass over all HASH_SLOTS valid bits runs first;
// in_tready is low meanwhile. The same sweep follows each image
// and each table restart when the codes run out.
// Output stall: words are held in out_tdata until out_tready; the packer
// and input wait behind it, nothing is lost.
module gif_lzw_compressor #(
  parameter int unsigned MAX_CODES  = glzw_pkg::DefMaxCodes,
  parameter int unsigned HASH_SLOTS = glzw_pkg::DefHashSlots
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [4:0]  out_tuser,  // [3:0] code_size, [4] bad_pixel
  output logic        out_tlast
);
  import glzw_pkg::*;

  logic [8:0] color_count_r;
  glzw_cmd_t cmd;
  glzw_sts_t sts;
  logic [3:0] min_size;
  logic err_flag;

  always_ff @(posedge clk) begin
    if (!rst_n) color_count_r <= 9'd256;
    else if (cfg_we) color_count_r <= cfg_wdata;
  end

  glzw_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_last(in_tlast),
    .out_tvalid, .out_tready, .out_last(out_tlast), .cmd, .sts
  );

  glzw_datapath #(.MAX_CODES(MAX_CODES), .HASH_SLOTS(HASH_SLOTS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .color_count(color_count_r),
    .in_pixel(in_tdata), .cur_byte(out_tdata), .min_size, .err_flag
  );

  assign out_tuser = {err_flag, min_size};
endmodule
